/* design/twsra_pkg.sv */
// ----------------------------------------------------------------------------
// twsra_pkg
// shared phase codes, constants and state/result structs for the three-wire
// serial register access unit
// ----------------------------------------------------------------------------
`default_nettype none

package twsra_pkg;

  localparam int PhaseW = 3;

  localparam logic [PhaseW-1:0] PH_IDLE  = 3'd0;
  localparam logic [PhaseW-1:0] PH_CEGAP = 3'd1;
  localparam logic [PhaseW-1:0] PH_CMD   = 3'd2;
  localparam logic [PhaseW-1:0] PH_MID   = 3'd3;
  localparam logic [PhaseW-1:0] PH_DATA  = 3'd4;
  localparam logic [PhaseW-1:0] PH_END   = 3'd5;
  localparam logic [PhaseW-1:0] PH_TAIL  = 3'd6;

  localparam logic [7:0] CMD_BASE      = 8'h80;
  localparam logic [7:0] DELAY_DEFAULT = 8'd15;
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [3:0]        bit_count;
    logic [7:0]        shift_byte;
    logic [7:0]        gap_count;
    logic [7:0]        pending_byte;
    logic              access_mode;
    logic [7:0]        read_byte;
  } twsra_state_t;

  typedef struct packed {
    logic       chip_enable;
    logic       serial_clock;
    logic       data_out;
    logic       data_drive;
    logic       busy_res;
    logic       read_valid;
    logic [7:0] read_data;
  } twsra_result_t;

endpackage : twsra_pkg

`default_nettype wire

/* design/three_wire_serial_register_access_unit.sv */
// ----------------------------------------------------------------------------
// three_wire_serial_register_access_unit
// bit-banged master for a three-wire serial clock chip, one sequencer tick
// per accepted request
// ----------------------------------------------------------------------------
//
//   channel  | handshake           | payload
//   ---------+---------------------+-------------------------------------------
//   in       | in_valid / in_ready | start_req mode reg_addr write_data
//            |                     | data_pin_in
//   out      | out_valid/out_ready | chip_enable serial_clock data_out
//            |                     | data_drive busy_res read_valid read_data
//   cfg      | cfg_we (no wait)    | cfg_wdata -> delay_ticks
//
// each request is one tick; the step logic is combinational between the
// sequencer state registers and the result register, so one request per
// cycle is accepted while the result register is free or being drained
// result is registered and appears in the cycle after its request is taken
// the result register sits between the sides: a new request is taken while
// the previous result is being taken in the same cycle
// synchronous reset clears the sequencer to idle and delay_ticks to 15
// ----------------------------------------------------------------------------
`default_nettype none

module three_wire_serial_register_access_unit (
  input  wire        clk,
  input  wire        rst,
  // request channel
  input  wire        in_valid,
  output logic       in_ready,
  input  wire        start_req,
  input  wire        mode,
  input  wire [4:0]  reg_addr,
  input  wire [7:0]  write_data,
  input  wire        data_pin_in,
  // result channel
  output logic       out_valid,
  input  wire        out_ready,
  output logic       chip_enable,
  output logic       serial_clock,
  output logic       data_out,
  output logic       data_drive,
  output logic       busy_res,
  output logic       read_valid,
  output logic [7:0] read_data,
  // configuration
  input  wire        cfg_we,
  input  wire [7:0]  cfg_wdata
);

  import twsra_pkg::*;

  // configuration register
  logic [7:0] delay_ticks;

  // sequencer state and the result register
  twsra_state_t  state;
  twsra_state_t  state_next;
  twsra_result_t res_next;
  twsra_result_t res;

  logic accept;

  // free slot when the result register is empty or being drained now
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_ticks <= DELAY_DEFAULT;
    end else if (cfg_we) begin
      delay_ticks <= cfg_wdata;
    end
  end

  twsra_step u_step (
    .cur         (state),
    .delay_ticks (delay_ticks),
    .start_req   (start_req),
    .mode        (mode),
    .reg_addr    (reg_addr),
    .write_data  (write_data),
    .data_pin_in (data_pin_in),
    .nxt         (state_next),
    .res         (res_next)
  );

  // state advances only on an accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  assign chip_enable  = res.chip_enable;
  assign serial_clock = res.serial_clock;
  assign data_out     = res.data_out;
  assign data_drive   = res.data_drive;
  assign busy_res     = res.busy_res;
  assign read_valid   = res.read_valid;
  assign read_data    = res.read_data;

  // every accepted tick leaves a result behind
  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted request produced no result");

  // sequencer never holds an unused phase code
  a_phase_legal: assert property (@(posedge clk) disable iff (rst)
    state.phase <= PH_TAIL)
    else $error("sequencer phase out of range");

  // pins are quiet whenever the access is not busy
  a_idle_pins: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !busy_res) |-> (!chip_enable && !serial_clock && !data_drive))
    else $error("pins active while not busy");

  // read completion comes with chip enable already dropped
  a_read_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && read_valid) |-> (busy_res && !chip_enable && !serial_clock))
    else $error("read done flagged during active access");

  // clock pulses only during the command or data byte
  a_clock_phase: assert property (@(posedge clk) disable iff (rst)
    (accept && res_next.serial_clock) |->
      (state.phase == PH_CMD || state.phase == PH_DATA))
    else $error("serial clock outside a byte transfer");

endmodule : three_wire_serial_register_access_unit

`default_nettype wire

/* design/twsra_step.sv */
// ----------------------------------------------------------------------------
// twsra_step
// one sequencer tick: next state and pin levels from the current state and
// one request
// ----------------------------------------------------------------------------
`default_nettype none

module twsra_step (
  input  wire twsra_pkg::twsra_state_t  cur,
  input  wire [7:0]                     delay_ticks,
  input  wire                           start_req,
  input  wire                           mode,
  input  wire [4:0]                     reg_addr,
  input  wire [7:0]                     write_data,
  input  wire                           data_pin_in,
  output twsra_pkg::twsra_state_t       nxt,
  output twsra_pkg::twsra_result_t      res
);

  import twsra_pkg::*;

  logic [7:0] eff_delay;
  assign eff_delay = (delay_ticks == 8'd0) ? 8'd1 : delay_ticks;

  always_comb begin
    twsra_state_t  st;
    twsra_result_t r;
    logic          reading;
    logic          rx;
    logic [7:0]    g;
    logic [3:0]    bc;

    st = cur;
    r  = '0;
    g  = '0;
    bc = '0;

    // unused phase code falls back to idle
    if (st.phase > PH_TAIL) begin
      st.phase = PH_IDLE;
    end

    if (st.phase == PH_IDLE && start_req) begin
      st.access_mode  = mode;
      st.shift_byte   = CMD_BASE | {2'b00, reg_addr, (mode == MODE_READ)};
      st.pending_byte = write_data;
      st.bit_count    = '0;
      st.gap_count    = eff_delay;
      st.phase        = PH_CEGAP;
    end

    reading = (st.access_mode == MODE_READ);
    rx      = (st.phase == PH_DATA) && reading;

    case (st.phase)
      PH_CEGAP, PH_MID, PH_END: begin
        r.chip_enable = 1'b1;
        r.busy_res    = 1'b1;
        r.data_drive  = !(st.phase == PH_END && reading);
        g = (st.gap_count != 8'd0) ? st.gap_count - 8'd1 : 8'd0;
        st.gap_count = g;
        if (g == 8'd0) begin
          if (st.phase == PH_CEGAP) begin
            st.phase     = PH_CMD;
            st.bit_count = '0;
          end else if (st.phase == PH_MID) begin
            st.phase     = PH_DATA;
            st.bit_count = '0;
            if (reading) begin
              st.read_byte = '0;
            end else begin
              st.shift_byte = st.pending_byte;
            end
          end else begin
            st.phase     = PH_TAIL;
            st.gap_count = reading ? 8'd1 : eff_delay;
          end
        end
      end
      PH_CMD, PH_DATA: begin
        r.chip_enable = 1'b1;
        r.busy_res    = 1'b1;
        r.data_drive  = !rx;
        r.data_out    = rx ? 1'b0 : st.shift_byte[0];
        if (st.gap_count == 8'd0) begin
          // clock low: data set up or pin sampled
          if (rx && st.bit_count < BITS_PER_BYTE) begin
            st.read_byte[st.bit_count[2:0]] = data_pin_in;
          end
          st.gap_count = eff_delay;
        end else begin
          r.serial_clock = 1'b1;
          g = st.gap_count - 8'd1;
          st.gap_count = g;
          if (g == 8'd0) begin
            st.shift_byte = {1'b0, st.shift_byte[7:1]};
            bc = st.bit_count + 4'd1;
            st.bit_count = bc;
            if (bc >= BITS_PER_BYTE) begin
              st.bit_count = '0;
              st.gap_count = eff_delay;
              st.phase     = (st.phase == PH_CMD) ? PH_MID : PH_END;
            end
          end
        end
      end
      PH_TAIL: begin
        r.busy_res   = 1'b1;
        r.read_valid = reading;
        g = (st.gap_count != 8'd0) ? st.gap_count - 8'd1 : 8'd0;
        st.gap_count = g;
        if (g == 8'd0) begin
          st.phase = PH_IDLE;
        end
      end
      default: begin
      end
    endcase

    r.read_data = st.read_byte;
    nxt = st;
    res = r;
  end

endmodule : twsra_step

`default_nettype wire
